// File: src/keyed_dirty_range_table_macros.svh
// Assertion macros for the keyed dirty range table.
// Included by the modules that carry assertions; no other dependencies.
`ifndef KEYED_DIRTY_RANGE_TABLE_MACROS_SVH
`define KEYED_DIRTY_RANGE_TABLE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define KDRT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define KDRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define KDRT_ASSERT_IMP(label, clk, rst, ante, cons)
`define KDRT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: src/kdrt_pkg.sv
// Shared types and constants for the keyed dirty range table.
// No dependencies.
package kdrt_pkg;
   localparam int ALIGN_ENTRIES_DEF    = 64;
   localparam int JUNCTION_ENTRIES_DEF = 64;

   typedef enum logic [2:0] {
      MODE_MARK_MICRO = 3'd0, MODE_MARK_SLOT = 3'd1, MODE_MARK_JUNC = 3'd2,
      MODE_GET_ALIGN = 3'd3, MODE_GET_JUNC = 3'd4, MODE_CLR_ALIGN = 3'd5,
      MODE_CLR_JUNC = 3'd6, MODE_CLR_ALL = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0, ST_ZERO_KEY = 2'd1, ST_FULL = 2'd2, ST_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]         mode;
      logic [31:0]        key;
      logic signed [63:0] bound_a;
      logic signed [63:0] bound_b;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               micro_dirty;
      logic signed [63:0] micro_lo;
      logic signed [63:0] micro_hi;
      logic               slot_dirty;
      logic signed [63:0] slot_lo;
      logic signed [63:0] slot_hi;
      logic               junction_flag;
   } rsp_type;

   // alignment entry as stored
   typedef struct packed {
      logic [31:0]        key;
      logic               mflag;
      logic signed [63:0] mlo;
      logic signed [63:0] mhi;
      logic               sflag;
      logic signed [63:0] slo;
      logic signed [63:0] shi;
   } aent_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request, reset search window
      logic bs_step;    // one binary search step
      logic rd_probe;   // issue read at search result
      logic shift_rd;   // read entry j-1
      logic shift_wr;   // write entry j from read data, j--
      logic ins_wr;     // write new zeroed entry at pos, used++
      logic upd_wr;     // write-back updated entry at pos
      logic clr_all;    // empty both tables
      logic respond;    // mark that a result strobe follows
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic bs_done;
      logic is_junc;
      logic found;
      logic full;
      logic shift_done;
      status_type pre_status; // zero-key / clear-all classification
      logic early;            // answer without search
      logic is_mark;
      logic is_get;
   } stat_type;
endpackage

// File: src/keyed_dirty_range_table.sv
// Top level of the keyed dirty range table: controller plus datapath.
// Depends on kdrt_pkg, kdrt_ctrl and kdrt_datapath.
//
//  channel  | handshake          | payload
//  request  | start / busy       | req_data (req_type)
//  response | rsp_strobe         | rsp_data (rsp_type)
//
// A search over n entries takes up to s = ceil(log2(n+1)) steps, each a read (S_BSRD) and a
// compare (S_BSCMP); the result then strobes in S_UPD after S_PROBE and S_CHECK.
// Insert shifts later entries up, each by S_SHRD then S_SHWR, then writes the new zeroed entry.
// Zero key and clear all strobe from S_UPD right after S_CLASS, with no search.
// start is taken again the cycle after the strobe.
// Reset empties both tables at once; entries are not cleared.
// Results cannot be stalled: each is shown for one cycle.
module keyed_dirty_range_table
   import kdrt_pkg::*;
#(
   parameter int ALIGN_ENTRIES    = ALIGN_ENTRIES_DEF,
   parameter int JUNCTION_ENTRIES = JUNCTION_ENTRIES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);
   cmd_type    cmd;
   stat_type   stat;
   rsp_type    dp_rsp;
   status_type st;

   kdrt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .stat(stat),
      .cmd(cmd), .rsp_strobe(rsp_strobe), .rsp_status(st)
   );

   kdrt_datapath #(.ALIGN_ENTRIES(ALIGN_ENTRIES), .JUNCTION_ENTRIES(JUNCTION_ENTRIES)) u_dp (
      .clock(clock), .reset(reset), .req_in(req_data), .cmd(cmd), .stat(stat),
      .rsp_out(dp_rsp)
   );

   always_comb begin
      rsp_data = '0;
      if (st == ST_DONE) rsp_data = dp_rsp;
      rsp_data.status = st;
   end
endmodule

// File: src/kdrt_datapath.sv
// Datapath: two sorted key tables held in memories, search window, shift and update.
// Depends on kdrt_pkg and the assertion macros header.
`include "keyed_dirty_range_table_macros.svh"
module kdrt_datapath
   import kdrt_pkg::*;
#(
   parameter int ALIGN_ENTRIES    = ALIGN_ENTRIES_DEF,
   parameter int JUNCTION_ENTRIES = JUNCTION_ENTRIES_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_in,
   input  cmd_type  cmd,
   output stat_type stat,
   output rsp_type  rsp_out
);
   localparam int AW = (ALIGN_ENTRIES > 1) ? $clog2(ALIGN_ENTRIES) : 1;
   localparam int JW = (JUNCTION_ENTRIES > 1) ? $clog2(JUNCTION_ENTRIES) : 1;
   localparam int IW = (AW > JW) ? AW : JW;
   localparam int CW = IW + 1;

   aent_type   amem [ALIGN_ENTRIES];
   logic [32:0] jmem [JUNCTION_ENTRIES];   // {key, flag}

   req_type    req_ff;
   logic [AW:0] aused_ff, aused_in;
   logic [JW:0] jused_ff, jused_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, j_ff, j_in;
   aent_type   ard_ff;
   logic [32:0] jrd_ff;

   logic          is_junc;
   logic          ld_junc;
   logic [CW-1:0] used_w, cap_w, mid_w;
   logic [31:0]   rd_key;

   assign is_junc = (req_ff.mode == MODE_MARK_JUNC) || (req_ff.mode == MODE_GET_JUNC)
                    || (req_ff.mode == MODE_CLR_JUNC);
   // table of the incoming request, used to open the search window on load
   assign ld_junc = (req_in.mode == MODE_MARK_JUNC) || (req_in.mode == MODE_GET_JUNC)
                    || (req_in.mode == MODE_CLR_JUNC);
   assign used_w  = is_junc ? CW'(jused_ff) : CW'(aused_ff);
   assign cap_w   = is_junc ? CW'(JUNCTION_ENTRIES) : CW'(ALIGN_ENTRIES);
   assign mid_w   = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign rd_key  = is_junc ? jrd_ff[32:1] : ard_ff.key;

   // memory reads: address chosen by command, data registered
   logic [CW-1:0] raddr;
   always_comb begin
      raddr = mid_w;
      if (cmd.rd_probe) raddr = lo_ff;
      if (cmd.shift_rd) raddr = j_ff - CW'(1);
   end
   always_ff @(posedge clock) begin
      ard_ff <= amem[raddr[AW-1:0]];
      jrd_ff <= jmem[raddr[JW-1:0]];
   end

   // widen helper
   logic signed [63:0] oa, ob, wlo, whi, olo, ohi;
   logic               oflag;
   aent_type           upd;
   always_comb begin
      oa = (req_ff.bound_b < req_ff.bound_a) ? req_ff.bound_b : req_ff.bound_a;
      ob = (req_ff.bound_b < req_ff.bound_a) ? req_ff.bound_a : req_ff.bound_b;
      upd   = ard_ff;
      oflag = (req_ff.mode == MODE_MARK_MICRO) ? ard_ff.mflag : ard_ff.sflag;
      olo   = (req_ff.mode == MODE_MARK_MICRO) ? ard_ff.mlo : ard_ff.slo;
      ohi   = (req_ff.mode == MODE_MARK_MICRO) ? ard_ff.mhi : ard_ff.shi;
      wlo = (!oflag || oa < olo) ? oa : olo;
      whi = (!oflag || ohi < ob) ? ob : ohi;
      case (req_ff.mode)
         MODE_MARK_MICRO: begin
            upd.mflag = 1'b1; upd.mlo = wlo; upd.mhi = whi;
         end
         MODE_MARK_SLOT: begin
            upd.sflag = 1'b1; upd.slo = wlo; upd.shi = whi;
         end
         MODE_CLR_ALIGN: begin
            upd.mflag = 1'b0; upd.sflag = 1'b0;
         end
         default: ;
      endcase
   end

   aent_type newent;
   always_comb begin
      newent     = '0;
      newent.key = req_ff.key;
   end

   always_ff @(posedge clock) begin
      if (!is_junc) begin
         if (cmd.shift_wr) amem[j_ff[AW-1:0]] <= ard_ff;
         else if (cmd.ins_wr) amem[lo_ff[AW-1:0]] <= newent;
         else if (cmd.upd_wr) amem[lo_ff[AW-1:0]] <= upd;
      end else begin
         if (cmd.shift_wr) jmem[j_ff[JW-1:0]] <= jrd_ff;
         else if (cmd.ins_wr) jmem[lo_ff[JW-1:0]] <= {req_ff.key, 1'b0};
         else if (cmd.upd_wr)
            jmem[lo_ff[JW-1:0]] <= {jrd_ff[32:1], req_ff.mode == MODE_MARK_JUNC};
      end
   end

   always_comb begin
      lo_in = lo_ff; hi_in = hi_ff; j_in = j_ff;
      aused_in = aused_ff; jused_in = jused_ff;
      if (cmd.load) begin
         lo_in = '0; hi_in = ld_junc ? CW'(jused_ff) : CW'(aused_ff);
      end
      if (cmd.bs_step) begin
         if (rd_key >= req_ff.key) hi_in = mid_w;
         else lo_in = mid_w + CW'(1);
      end
      if (cmd.rd_probe) j_in = used_w;
      if (cmd.shift_wr) j_in = j_ff - CW'(1);
      if (cmd.ins_wr) begin
         if (is_junc) jused_in = jused_ff + 1'b1;
         else aused_in = aused_ff + 1'b1;
      end
      if (cmd.clr_all) begin
         aused_in = '0; jused_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         aused_ff <= '0;
         jused_ff <= '0;
      end else begin
         aused_ff <= aused_in;
         jused_ff <= jused_in;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      j_ff  <= j_in;
      if (cmd.load) req_ff <= req_in;
   end

   always_comb begin
      stat.bs_done    = (lo_ff >= hi_ff);
      stat.is_junc    = is_junc;
      stat.found      = (lo_ff < used_w) && (rd_key == req_ff.key);
      stat.full       = (used_w >= cap_w);
      stat.shift_done = (j_ff <= lo_ff);
      stat.is_mark    = (req_ff.mode == MODE_MARK_MICRO) || (req_ff.mode == MODE_MARK_SLOT)
                        || (req_ff.mode == MODE_MARK_JUNC);
      stat.is_get     = (req_ff.mode == MODE_GET_ALIGN) || (req_ff.mode == MODE_GET_JUNC);
      stat.early      = (req_ff.mode == MODE_CLR_ALL) || (req_ff.key == '0);
      stat.pre_status = (req_ff.mode == MODE_CLR_ALL) ? ST_DONE : ST_ZERO_KEY;
   end

   // result payload, zero unless a get; the top level zeroes it unless the status is done
   always_comb begin
      rsp_out = '0;
      if (req_ff.mode == MODE_GET_ALIGN) begin
         rsp_out.micro_dirty = ard_ff.mflag;
         rsp_out.micro_lo    = ard_ff.mlo;
         rsp_out.micro_hi    = ard_ff.mhi;
         rsp_out.slot_dirty  = ard_ff.sflag;
         rsp_out.slot_lo     = ard_ff.slo;
         rsp_out.slot_hi     = ard_ff.shi;
      end
      if (req_ff.mode == MODE_GET_JUNC) rsp_out.junction_flag = jrd_ff[0];
   end

   `KDRT_ASSERT_IMP(a_used_cap_a, clock, reset, 1'b1, aused_ff <= (AW+1)'(ALIGN_ENTRIES))
   `KDRT_ASSERT_IMP(a_used_cap_j, clock, reset, 1'b1, jused_ff <= (JW+1)'(JUNCTION_ENTRIES))
   `KDRT_ASSERT_IMP(a_ins_not_full, clock, reset, cmd.ins_wr, !stat.full)
endmodule

// File: src/kdrt_ctrl.sv
// Controller: sequences search, insert shifting, update and response.
// Depends on kdrt_pkg and the assertion macros header.
`include "keyed_dirty_range_table_macros.svh"
module kdrt_ctrl
   import kdrt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     rsp_strobe,
   output status_type rsp_status
);
   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001, S_CLASS = 9'b000000010, S_BSRD = 9'b000000100,
      S_BSCMP = 9'b000001000, S_PROBE = 9'b000010000, S_CHECK = 9'b000100000,
      S_SHRD = 9'b001000000, S_SHWR = 9'b010000000, S_UPD = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   status_type status_ff, status_in;
   logic after_ins_ff, after_ins_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff; status_in = status_ff; after_ins_in = after_ins_ff;
      cmd = '0;
      rsp_strobe = 1'b0;
      case (state_ff)
         S_IDLE: if (start) begin
            cmd.load = 1'b1; state_in = S_CLASS;
         end
         S_CLASS: begin
            if (stat.early) begin
               cmd.clr_all = stat.pre_status == ST_DONE;
               status_in = stat.pre_status; cmd.respond = 1'b1; state_in = S_UPD;
            end else state_in = S_BSRD;
            after_ins_in = 1'b0;
         end
         S_BSRD: state_in = stat.bs_done ? S_PROBE : S_BSCMP;  // read at mid lands
         S_BSCMP: begin
            cmd.bs_step = 1'b1; state_in = S_BSRD;
         end
         S_PROBE: begin
            cmd.rd_probe = 1'b1; state_in = S_CHECK;
         end
         S_CHECK: begin
            if (stat.found || after_ins_ff) begin
               if (stat.is_get) begin
                  status_in = ST_DONE; cmd.respond = 1'b1; state_in = S_UPD;
               end else begin
                  cmd.upd_wr = 1'b1; status_in = ST_DONE;
                  cmd.respond = 1'b1; state_in = S_UPD;
               end
            end else if (!stat.is_mark) begin
               status_in = ST_NOT_FOUND; cmd.respond = 1'b1; state_in = S_UPD;
            end else if (stat.full) begin
               status_in = ST_FULL; cmd.respond = 1'b1; state_in = S_UPD;
            end else state_in = stat.shift_done ? S_UPD : S_SHRD;
            if (state_in == S_UPD && !cmd.respond) begin
               cmd.ins_wr = 1'b1; after_ins_in = 1'b1; state_in = S_PROBE;
            end
         end
         S_SHRD: begin
            cmd.shift_rd = 1'b1; state_in = S_SHWR;
         end
         S_SHWR: begin
            cmd.shift_wr = 1'b1;
            state_in = S_SHRD;
            if (stat.shift_done) state_in = S_SHRD;
         end
         S_UPD: begin
            rsp_strobe = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // shift loop exit: after last write go insert
      if (state_ff == S_SHRD && stat.shift_done) begin
         cmd.shift_rd = 1'b0; cmd.ins_wr = 1'b1; after_ins_in = 1'b1; state_in = S_PROBE;
      end
   end

   assign rsp_status = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         status_ff <= ST_DONE;
         after_ins_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         status_ff <= status_in;
         after_ins_ff <= after_ins_in;
      end
   end

   `KDRT_ASSERT_NEXT(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   `KDRT_ASSERT_IMP(a_no_start_rsp, clock, reset, rsp_strobe, busy)
   `KDRT_ASSERT_IMP(a_one_write, clock, reset, cmd.ins_wr, !cmd.upd_wr && !cmd.shift_wr)
endmodule

// File: bench/keyed_dirty_range_table_tb.sv
// Testbench for keyed_dirty_range_table: sorted alignment and junction tables
// with dirty ranges, checked against an in-bench model of both tables.
// Depends on kdrt_pkg and the keyed_dirty_range_table RTL.
`timescale 1ns / 1ps
module keyed_dirty_range_table_tb;
   import kdrt_pkg::*;

   localparam int NA = ALIGN_ENTRIES_DEF;
   localparam int NJ = JUNCTION_ENTRIES_DEF;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   keyed_dirty_range_table dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // table model
   aent_type    align_tab[NA];
   int          align_cnt;
   logic [31:0] junc_key[NJ];
   logic        junc_flag[NJ];
   int          junc_cnt;

   rsp_type expected_rsps[$];
   int      mismatches;
   int      send_idle_pct;

   function automatic int lower_pos(input bit is_junc, input logic [31:0] k);
      int lo, hi, mid;
      lo = 0;
      hi = is_junc ? junc_cnt : align_cnt;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if ((is_junc ? junc_key[mid] : align_tab[mid].key) >= k) hi = mid;
         else lo = mid + 1;
      end
      return lo;
   endfunction

   task automatic widen_range(inout logic flag, inout logic signed [63:0] lo_s,
                              inout logic signed [63:0] hi_s,
                              input logic signed [63:0] a, input logic signed [63:0] b);
      logic signed [63:0] lo, hi;
      lo = (b < a) ? b : a;
      hi = (b < a) ? a : b;
      if (!flag) begin
         flag = 1'b1; lo_s = lo; hi_s = hi;
      end else begin
         if (lo < lo_s) lo_s = lo;
         if (hi_s < hi) hi_s = hi;
      end
   endtask

   task automatic predict_table(input req_type r, output rsp_type o);
      int p, j;
      bit hit;
      o = '0;
      o.status = ST_DONE;
      if (mode_type'(r.mode) == MODE_CLR_ALL) begin
         align_cnt = 0; junc_cnt = 0;
      end else if (r.key == 0) begin
         o.status = ST_ZERO_KEY;
      end else if (r.mode <= MODE_MARK_SLOT) begin
         p = lower_pos(0, r.key);
         hit = p < align_cnt && align_tab[p].key == r.key;
         if (!hit && align_cnt >= NA) o.status = ST_FULL;
         else begin
            if (!hit) begin
               for (j = align_cnt; j > p; j--) align_tab[j] = align_tab[j-1];
               align_tab[p] = '0;
               align_tab[p].key = r.key;
               align_cnt++;
            end
            if (mode_type'(r.mode) == MODE_MARK_MICRO)
               widen_range(align_tab[p].mflag, align_tab[p].mlo, align_tab[p].mhi,
                           r.bound_a, r.bound_b);
            else
               widen_range(align_tab[p].sflag, align_tab[p].slo, align_tab[p].shi,
                           r.bound_a, r.bound_b);
         end
      end else if (mode_type'(r.mode) == MODE_MARK_JUNC) begin
         p = lower_pos(1, r.key);
         hit = p < junc_cnt && junc_key[p] == r.key;
         if (!hit && junc_cnt >= NJ) o.status = ST_FULL;
         else begin
            if (!hit) begin
               for (j = junc_cnt; j > p; j--) begin
                  junc_key[j] = junc_key[j-1]; junc_flag[j] = junc_flag[j-1];
               end
               junc_key[p] = r.key;
               junc_cnt++;
            end
            junc_flag[p] = 1'b1;
         end
      end else if (r.mode == MODE_GET_ALIGN || r.mode == MODE_CLR_ALIGN) begin
         p = lower_pos(0, r.key);
         if (!(p < align_cnt && align_tab[p].key == r.key)) o.status = ST_NOT_FOUND;
         else if (mode_type'(r.mode) == MODE_GET_ALIGN) begin
            o.micro_dirty = align_tab[p].mflag;
            o.micro_lo = align_tab[p].mlo;
            o.micro_hi = align_tab[p].mhi;
            o.slot_dirty = align_tab[p].sflag;
            o.slot_lo = align_tab[p].slo;
            o.slot_hi = align_tab[p].shi;
         end else begin
            align_tab[p].mflag = 1'b0; align_tab[p].sflag = 1'b0;
         end
      end else begin
         p = lower_pos(1, r.key);
         if (!(p < junc_cnt && junc_key[p] == r.key)) o.status = ST_NOT_FOUND;
         else if (mode_type'(r.mode) == MODE_GET_JUNC) o.junction_flag = junc_flag[p];
         else junc_flag[p] = 1'b0;
      end
   endtask

   // drive at falling edge, hold until accepted
   task automatic send_request(input mode_type m, input logic [31:0] k,
                               input logic signed [63:0] a = 0,
                               input logic signed [63:0] b = 0);
      req_type r;
      rsp_type o;
      r.mode = m; r.key = k; r.bound_a = a; r.bound_b = b;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_data <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      predict_table(r, o);
      expected_rsps.push_back(o);
      @(negedge clock);
      start <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", rsp_data);
         end else if (rsp_data !== expected_rsps[0]) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response mismatch: expected %h actual %h",
                        expected_rsps[0], rsp_data);
            void'(expected_rsps.pop_front());
         end else void'(expected_rsps.pop_front());
      end
   end

   task automatic wait_drained();
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   function automatic logic signed [63:0] rand_bound();
      case ($urandom_range(5))
         0: return 64'sh8000000000000000;
         1: return 64'sh7fffffffffffffff;
         2: return $signed(64'($urandom_range(200))) - 100;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic test_directed();
      send_request(MODE_MARK_MICRO, 0, 1, 2);
      send_request(MODE_GET_ALIGN, 0);
      send_request(MODE_CLR_JUNC, 0);
      send_request(MODE_GET_ALIGN, 5);
      send_request(MODE_GET_JUNC, 5);
      send_request(MODE_CLR_ALIGN, 5);
      send_request(MODE_CLR_JUNC, 5);
      send_request(MODE_MARK_MICRO, 32'hffffffff, 64'sh7fffffffffffffff,
                   64'sh8000000000000000);
      send_request(MODE_MARK_MICRO, 32'hffffffff, 10, -10);
      send_request(MODE_MARK_SLOT, 32'hffffffff, -5, 5);
      send_request(MODE_MARK_SLOT, 32'hffffffff, 100, 200);
      send_request(MODE_MARK_SLOT, 1, 3, 3);
      send_request(MODE_GET_ALIGN, 32'hffffffff);
      send_request(MODE_GET_ALIGN, 1);
      send_request(MODE_MARK_JUNC, 32'h80000000);
      send_request(MODE_GET_JUNC, 32'h80000000);
      send_request(MODE_CLR_ALIGN, 32'hffffffff);
      send_request(MODE_CLR_JUNC, 32'h80000000);
      send_request(MODE_GET_ALIGN, 32'hffffffff);
      send_request(MODE_MARK_MICRO, 32'hffffffff, 7, 8);
      send_request(MODE_GET_ALIGN, 32'hffffffff);
      send_request(MODE_GET_JUNC, 32'h80000000);
      send_request(MODE_CLR_ALL, 0);
      send_request(MODE_GET_ALIGN, 32'hffffffff);
   endtask

   // fill both tables past capacity, then probe existing keys in the full tables
   task automatic test_full_tables();
      int i;
      for (i = 0; i < NA + 3; i++) begin
         send_request(MODE_MARK_SLOT, {$urandom} | 32'h1, rand_bound(), rand_bound());
         send_request(MODE_MARK_JUNC, {$urandom} | 32'h1);
      end
      send_request(MODE_MARK_MICRO, align_tab[0].key, 1, 2);
      send_request(MODE_MARK_JUNC, junc_key[NJ-1]);
      send_request(MODE_GET_ALIGN, align_tab[NA-1].key);
      wait_drained();
      send_request(MODE_CLR_ALL, $urandom);
   endtask

   task automatic test_random(input int n);
      int i;
      logic [31:0] k;
      mode_type m;
      for (i = 0; i < n; i++) begin
         // small key pool gives frequent hits; sometimes any key
         case ($urandom_range(9))
            0: k = 0;
            1: k = $urandom;
            2: k = 32'hffffffff - $urandom_range(40);
            default: k = $urandom_range(40) + 1;
         endcase
         m = mode_type'($urandom_range(7));
         if (m == MODE_CLR_ALL && $urandom_range(4) != 0) m = MODE_GET_ALIGN;
         send_request(m, k, rand_bound(), rand_bound());
      end
   endtask

   initial begin
      mismatches = 0;
      align_cnt = 0;
      junc_cnt = 0;
      send_idle_pct = 10;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_tables();
      test_random(350);
      wait_drained();
      send_idle_pct = 79;
      test_random(350);
      send_idle_pct = 0;
      test_random(300);
      wait_drained();
      repeat (300) @(negedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #20ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
